// ===== hw/rtl/lcgr_pkg.sv =====
// ============================================================================
// lcgr_pkg: shared definitions for the ranged LCG random generator
// Holds the generator constants and the command and register codes that the
// top level uses, and the divider sizing that the remainder unit uses.
// ============================================================================
package lcgr_pkg;

   // Generator arithmetic
   localparam logic [31:0] LcgMul   = 32'd1103515245;
   localparam logic [31:0] LcgAdd   = 32'd12345;
   localparam int          TapShift = 16;
   localparam int          TapHiW   = 11;
   localparam int          TapLoW   = 10;
   localparam int          LcgSteps = 3;

   // Field widths
   localparam int DataW = 32;
   localparam int RawW  = 31;

   // Remainder unit: one quotient bit per cycle over the raw word
   localparam int DivSteps = RawW;
   localparam int DivCntW  = $clog2(DivSteps);

   // Command codes
   localparam logic CmdSeed = 1'b0;
   localparam logic CmdDraw = 1'b1;

   // Register indexes
   localparam logic CsrRangeLow  = 1'b0;
   localparam logic CsrRangeHigh = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      StIdle    = 4'b0001,
      StAdvance = 4'b0010,
      StDivide  = 4'b0100,
      StFinish  = 4'b1000
   } state_type;

   // Handshake between sequencer and remainder unit
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hw/rtl/lcgr_div.sv =====
// ============================================================================
// lcgr_div: serial remainder unit
// Restoring division of the 31-bit raw word by a 32-bit span, one quotient
// bit per cycle. Only the remainder is kept.
// ============================================================================
module lcgr_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lcgr_pkg::RawW-1:0]      dividend,
   input  logic [lcgr_pkg::DataW-1:0]     divisor,
   output lcgr_pkg::div_status_type       status,
   output logic [lcgr_pkg::DataW-1:0]     remainder
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [lcgr_pkg::DivCntW-1:0]  cnt_ff, cnt_in;
   logic [lcgr_pkg::DataW-1:0]    rem_ff, rem_in;
   logic [lcgr_pkg::RawW-1:0]     quo_ff, quo_in;
   logic [lcgr_pkg::DataW:0]      shifted;
   logic [lcgr_pkg::DataW:0]      trial;

   // Shift in the next dividend bit and try to subtract the divisor
   assign shifted = {rem_ff, quo_ff[lcgr_pkg::RawW-1]};
   assign trial   = shifted - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // Keep the difference when it did not go negative
         if (!trial[lcgr_pkg::DataW]) begin
            rem_in = trial[lcgr_pkg::DataW-1:0];
         end else begin
            rem_in = shifted[lcgr_pkg::DataW-1:0];
         end
         quo_in = {quo_ff[lcgr_pkg::RawW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == lcgr_pkg::DivCntW'(lcgr_pkg::DivSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

// ===== hw/rtl/lcg_random_in_range.sv =====
// ============================================================================
// lcg_random_in_range: ranged draws from a 32-bit linear congruential
// generator
// Seed transactions add to the generator word; draw transactions advance it
// three times, pack a 31-bit raw word and reduce it into [low, high].
// ============================================================================
// One transaction is taken at a time; req_stall stays high from acceptance
// until its result is loaded into the output register, and the next
// transaction can be accepted on the following cycle. A seed, or a draw with
// range_high not above range_low, goes from the idle state straight to the
// finish state and is loaded from there. A draw advances the generator in
// the advance state through the shared 32x32 constant multiplier (one
// generator step per cycle), runs the serial remainder unit (one quotient
// bit per cycle), picks up the remainder in the divide state and loads the
// result from the finish state. A full 32-bit span skips the remainder unit
// and goes from the advance state straight to the finish state. While an
// earlier result waits on rsp_stall, a finished result holds in the sequencer
// and the input stays stalled until the output register is free. Range
// registers are written through csr_write/csr_index/csr_data; the user must
// write them only while the block is idle; the block does not enforce this.
// ============================================================================
module lcg_random_in_range (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic [lcgr_pkg::DataW-1:0]    req_seed_value,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lcgr_pkg::DataW-1:0]    rsp_ranged_value,
   output logic [lcgr_pkg::RawW-1:0]     rsp_raw_value,
   // configuration port
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [lcgr_pkg::DataW-1:0]    csr_data
);

   lcgr_pkg::state_type            state_ff, state_in;
   logic [1:0]                     step_ff, step_in;
   logic [lcgr_pkg::DataW-1:0]     gen_ff, gen_in;
   logic [lcgr_pkg::DataW-1:0]     low_ff, low_in;
   logic [lcgr_pkg::DataW-1:0]     high_ff, high_in;
   logic [lcgr_pkg::RawW-1:0]      raw_ff, raw_in;
   logic [lcgr_pkg::DataW-1:0]     res_ranged_ff, res_ranged_in;
   logic [lcgr_pkg::RawW-1:0]      res_raw_ff, res_raw_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lcgr_pkg::DataW-1:0]     rsp_ranged_ff, rsp_ranged_in;
   logic [lcgr_pkg::RawW-1:0]      rsp_raw_ff, rsp_raw_in;

   logic                           req_take;
   logic                           out_free;
   logic [lcgr_pkg::DataW-1:0]     gen_step;
   logic [lcgr_pkg::DataW-1:0]     span;
   logic                           div_start;
   lcgr_pkg::div_status_type       div_status;
   logic [lcgr_pkg::DataW-1:0]     div_rem;

   assign req_stall = (state_ff != lcgr_pkg::StIdle);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // One generator step: multiply by the constant and add the increment
   assign gen_step = 32'(gen_ff * lcgr_pkg::LcgMul) + lcgr_pkg::LcgAdd;

   // Inclusive span; wraps to zero for the full 32-bit range
   assign span = high_ff - low_ff + 32'd1;

   // Configuration writes
   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_write) begin
         case (csr_index)
            lcgr_pkg::CsrRangeLow:  low_in  = csr_data;
            lcgr_pkg::CsrRangeHigh: high_in = csr_data;
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      gen_in        = gen_ff;
      raw_in        = raw_ff;
      res_ranged_in = res_ranged_ff;
      res_raw_in    = res_raw_ff;
      div_start     = 1'b0;
      case (state_ff)
         lcgr_pkg::StIdle: begin
            if (req_take) begin
               if (req_command == lcgr_pkg::CmdSeed) begin
                  gen_in        = gen_ff + req_seed_value;
                  res_ranged_in = '0;
                  res_raw_in    = '0;
                  state_in      = lcgr_pkg::StFinish;
               end else if (high_ff > low_ff) begin
                  step_in  = '0;
                  state_in = lcgr_pkg::StAdvance;
               end else begin
                  res_ranged_in = low_ff;
                  res_raw_in    = '0;
                  state_in      = lcgr_pkg::StFinish;
               end
            end
         end
         lcgr_pkg::StAdvance: begin
            // Advance the generator and pack its tapped bits
            gen_in = gen_step;
            if (step_ff == 2'd0) begin
               raw_in = lcgr_pkg::RawW'(
                  gen_step[lcgr_pkg::TapShift +: lcgr_pkg::TapHiW]);
            end else begin
               raw_in = {raw_ff[lcgr_pkg::RawW-lcgr_pkg::TapLoW-1:0],
                         gen_step[lcgr_pkg::TapShift +: lcgr_pkg::TapLoW]};
            end
            step_in = step_ff + 2'd1;
            if (step_ff == 2'(lcgr_pkg::LcgSteps - 1)) begin
               if (span == '0) begin
                  res_ranged_in = low_ff + {1'b0, raw_in};
                  res_raw_in    = raw_in;
                  state_in      = lcgr_pkg::StFinish;
               end else begin
                  div_start = 1'b1;
                  state_in  = lcgr_pkg::StDivide;
               end
            end
         end
         lcgr_pkg::StDivide: begin
            if (div_status.done) begin
               res_ranged_in = low_ff + div_rem;
               res_raw_in    = raw_ff;
               state_in      = lcgr_pkg::StFinish;
            end
         end
         lcgr_pkg::StFinish: begin
            if (out_free) begin
               state_in = lcgr_pkg::StIdle;
            end
         end
         default: begin
            state_in = lcgr_pkg::StIdle;
         end
      endcase
   end

   // Output register: load when free, drop once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_ranged_in = rsp_ranged_ff;
      rsp_raw_in    = rsp_raw_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == lcgr_pkg::StFinish && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_ranged_in = res_ranged_ff;
         rsp_raw_in    = res_raw_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcgr_pkg::StIdle;
         step_ff      <= '0;
         gen_ff       <= '0;
         low_ff       <= '0;
         high_ff      <= 32'd3;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         gen_ff       <= gen_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff        <= raw_in;
      res_ranged_ff <= res_ranged_in;
      res_raw_ff    <= res_raw_in;
      rsp_ranged_ff <= rsp_ranged_in;
      rsp_raw_ff    <= rsp_raw_in;
   end

   lcgr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (raw_in),
      .divisor   (span),
      .status    (div_status),
      .remainder (div_rem)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_ranged_value = rsp_ranged_ff;
   assign rsp_raw_value    = rsp_raw_ff;

endmodule
